@@ rtl/b64c_pkg.sv @@
`default_nettype none

package b64c_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned SextWidth  = 6;
  localparam int unsigned GroupChars = 4;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [CharWidth-1:0] char_t;
  typedef logic [SextWidth-1:0] sext_t;

  // map a six-bit index onto its alphabet character
  function automatic char_t enc_char(sext_t idx);
    char_t wide;
    char_t ch;
    wide = {2'b00, idx};
    priority if (idx == 6'd0) begin
      ch = "X";
    end else if (idx <= 6'd26) begin
      ch = wide + 8'h60;
    end else if (idx <= 6'd49) begin
      ch = wide + 8'd38;
    end else if (idx == 6'd50) begin
      ch = "Y";
    end else if (idx == 6'd51) begin
      ch = "Z";
    end else if (idx <= 6'd61) begin
      ch = wide - 8'd4;
    end else if (idx == 6'd62) begin
      ch = "_";
    end else begin
      ch = ".";
    end
    return ch;
  endfunction

  // map a character back to its index; anything outside the alphabet gives zero
  function automatic sext_t dec_char(char_t ch);
    char_t val;
    priority if (ch >= "a" && ch <= "z") begin
      val = ch - 8'h60;
    end else if (ch >= "A" && ch <= "W") begin
      val = ch - 8'd38;
    end else if (ch == "Y") begin
      val = 8'd50;
    end else if (ch == "Z") begin
      val = 8'd51;
    end else if (ch >= "0" && ch <= "9") begin
      val = ch + 8'd4;
    end else if (ch == "_") begin
      val = 8'd62;
    end else if (ch == ".") begin
      val = 8'd63;
    end else begin
      val = 8'd0;
    end
    return val[SextWidth-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/b64c_in_stage.sv @@
`default_nettype none

module b64c_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire b64c_pkg::op_e   operation_i,
  input  wire b64c_pkg::data_t data_in_i,
  output logic                 s1_valid_o,
  input  wire logic            s1_ready_i,
  output b64c_pkg::op_e        s1_op_o,
  output b64c_pkg::data_t      s1_data_o
);
  import b64c_pkg::*;

  logic  valid_q, valid_d;
  op_e   op_q;
  data_t data_q;

  assign in_ready_o = !valid_q || s1_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= operation_i;
      data_q <= data_in_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_op_o    = op_q;
  assign s1_data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/b64c_map.sv @@
`default_nettype none

module b64c_map (
  input  wire b64c_pkg::op_e   op_i,
  input  wire b64c_pkg::data_t data_i,
  output b64c_pkg::data_t      data_o
);
  import b64c_pkg::*;

  logic [GroupChars*SextWidth-1:0] enc_bits;
  logic [GroupChars*SextWidth-1:0] dec_bits;
  data_t                           enc_word;
  data_t                           dec_word;

  assign enc_bits = data_i[GroupChars*SextWidth-1:0];

  for (genvar g = 0; g < GroupChars; g++) begin : g_lane
    assign enc_word[g*CharWidth +: CharWidth] = enc_char(enc_bits[g*SextWidth +: SextWidth]);
    assign dec_bits[g*SextWidth +: SextWidth] = dec_char(data_i[g*CharWidth +: CharWidth]);
  end

  assign dec_word = {{(DataWidth-GroupChars*SextWidth){1'b0}}, dec_bits};

  always_comb begin
    unique case (op_i)
      OP_ENCODE: data_o = enc_word;
      OP_DECODE: data_o = dec_word;
      default:   data_o = enc_word;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/base64_custom_alphabet_codec_unit.sv @@
`default_nettype none

// Base64-style group codec over the alphabet X, a-z, A-W, Y, Z, 0-9, '_', '.'.
// operation_i = 0 encodes the three bytes in data_in_i[23:0] (first byte on top)
// into four characters, first character in data_out_o[31:24]; operation_i = 1
// decodes four characters into three bytes in data_out_o[23:0] with the top byte
// zero. Characters outside the alphabet decode as 'X' (zero) with no error flag.
// An accepted transaction passes the input register, then the result register.
// One transaction is accepted every cycle while the output side keeps taking
// results; a stalled output backs up through both registers.
module base64_custom_alphabet_codec_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire b64c_pkg::op_e   operation_i,
  input  wire b64c_pkg::data_t data_in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output b64c_pkg::data_t      data_out_o
);
  import b64c_pkg::*;

  logic  s1_valid;
  logic  s1_ready;
  op_e   s1_op;
  data_t s1_data;
  data_t map_data;

  logic  out_valid_q, out_valid_d;
  data_t out_data_q;

  b64c_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_in_i   (data_in_i),
    .s1_valid_o  (s1_valid),
    .s1_ready_i  (s1_ready),
    .s1_op_o     (s1_op),
    .s1_data_o   (s1_data)
  );

  b64c_map u_map (
    .op_i   (s1_op),
    .data_i (s1_data),
    .data_o (map_data)
  );

  assign s1_ready    = !out_valid_q || out_ready_i;
  assign out_valid_d = s1_ready ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid && s1_ready) begin
      out_data_q <= map_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

`ifndef SYNTHESIS
  a_ready_only_on_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");

  a_stage_moves_to_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_ready) |=> out_valid_o)
    else $error("transaction lost between stages");

  a_decode_top_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_ready && s1_op == OP_DECODE) |=> (data_out_o[31:24] == 8'h00))
    else $error("decode result has nonzero top byte");

  a_stalled_result_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_q))
    else $error("result register changed under stall");
`endif

endmodule

`default_nettype wire

@@ tb/tb_base64_custom_alphabet_codec_unit.sv @@
`timescale 1ns / 1ps

class group_checker;
  typedef b64c_pkg::data_t data_t;
  typedef b64c_pkg::op_e op_e;

  bit [7:0] glyph[64];
  bit [5:0] glyph_rank[256];
  data_t expected_groups[$];
  int mismatches;

  function new();
    string letters;
    letters = "XabcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWYZ0123456789_.";
    mismatches = 0;
    foreach (glyph_rank[i]) glyph_rank[i] = '0;
    for (int i = 0; i < 64; i++) begin
      glyph[i] = letters[i];
      glyph_rank[letters[i]] = 6'(i);
    end
  endfunction

  function data_t predict_group(op_e op, data_t word);
    data_t result;
    bit [23:0] bits24;
    result = '0;
    bits24 = '0;
    if (op == b64c_pkg::OP_ENCODE) begin
      for (int k = 0; k < 4; k++) begin
        result[31-8*k -: 8] = glyph[word[23-6*k -: 6]];
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        bits24 = {bits24[17:0], glyph_rank[word[31-8*k -: 8]]};
      end
      result = {8'h00, bits24};
    end
    return result;
  endfunction

  function void note_group(op_e op, data_t word);
    expected_groups.push_back(predict_group(op, word));
  endfunction

  function void check_group(data_t got);
    data_t want;
    if (expected_groups.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: data_out=%h", got);
      return;
    end
    want = expected_groups.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("data_out mismatch: expected %h, actual %h", want, got);
    end
  endfunction

  function int pending();
    return expected_groups.size();
  endfunction
endclass

module tb_base64_custom_alphabet_codec_unit;
  import b64c_pkg::*;

  localparam int RandomItems = 1450;
  localparam int CalmItems = 150;
  localparam int HoldAt = 300;
  localparam int HoldCycles = 80;
  localparam int StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  op_e operation_i = OP_ENCODE;
  data_t data_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  data_t data_out_o;

  group_checker sb = new();

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int gap_pct = 20;
  int stall_pct = 20;
  int quiet_cycles = 0;

  base64_custom_alphabet_codec_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_group(operation_i, data_in_i);
      if (out_valid_o && out_ready_i) sb.check_group(data_out_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drive_group(op_e op, data_t word);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    data_in_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic sender_idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < gap_pct) sender_idle($urandom_range(1, 7));
  endtask

  function automatic data_t random_chars();
    data_t word;
    string letters;
    letters = "XabcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWYZ0123456789_.";
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 9) < 8) word[8*k +: 8] = letters[$urandom_range(0, 63)];
      else word[8*k +: 8] = 8'($urandom);
    end
    return word;
  endfunction

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 7);
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int settle;
    data_t word;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sweep all 64 sextet values through the encoder
    for (int j = 0; j < 16; j++) begin
      word = {8'h00, 6'(4*j), 6'(4*j+1), 6'(4*j+2), 6'(4*j+3)};
      maybe_idle();
      drive_group(OP_ENCODE, word);
    end
    drive_group(OP_ENCODE, 32'hFFFF_FFFF);
    drive_group(OP_ENCODE, 32'hA5FF_0000);
    drive_group(OP_DECODE, "XXXX");
    drive_group(OP_DECODE, "aAY0");
    drive_group(OP_DECODE, "zWZ9");
    drive_group(OP_DECODE, "_._.");
    drive_group(OP_DECODE, 32'hFFFF_FFFF);
    drive_group(OP_DECODE, 32'h0000_0000);
    drive_group(OP_DECODE, "[@`{");

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (i == HoldAt) hold_req = 1'b1;
      if (i == RandomItems - CalmItems) calm = 1'b1;
      if (!(hold_req && !hold_done)) maybe_idle();
      if ($urandom_range(0, 1) == 0) drive_group(OP_ENCODE, $urandom);
      else drive_group(OP_DECODE, random_chars());
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    settle = 0;
    while (sb.pending() != 0 && settle < StallLimit) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ base64_custom_alphabet_codec_unit.f @@
rtl/b64c_pkg.sv
rtl/b64c_in_stage.sv
rtl/b64c_map.sv
rtl/base64_custom_alphabet_codec_unit.sv
tb/tb_base64_custom_alphabet_codec_unit.sv
